>>> rtl/abte_pkg.sv
package abte_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [31:0] EMPTY_SLOT = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        FN_INSERT   = 4'd0,
        FN_APPEND   = 4'd1,
        FN_DELETE   = 4'd2,
        FN_SEARCH   = 4'd3,
        FN_COUNT    = 4'd4,
        FN_HEIGHT   = 4'd5,
        FN_COMPLETE = 4'd6,
        FN_PRE      = 4'd7,
        FN_IN       = 4'd8,
        FN_POST     = 4'd9,
        FN_LEVEL    = 4'd10
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERWROTE  = 3'd1,
        ST_OOB        = 3'd2,
        ST_FULL       = 3'd3,
        ST_INVALID    = 3'd4,
        ST_NOT_FOUND  = 3'd5,
        ST_EMPTY_TRAV = 3'd6
    } status_t;

endpackage

>>> rtl/array_binary_tree_engine_unit.sv
// Binary tree kept in a node store of CAPACITY 32-bit slots, children of slot i at
// 2i+1 and 2i+2, empty slots hold -1. After reset the store is swept to empty, one
// slot per cycle, so the block takes no transaction until the sweep is done.
// Search, count, completeness and level order read the store one slot per cycle
// through its single read port, while the output does not stall a level-order
// emit. Height and the pre-, in- and post-order walks step through the tree one
// move per cycle, while the output does not stall an emit, with no stack,
// climbing back through the parent index. Every operation waits at its end
// until the output is free. One transaction is worked at a time; s_tready is
// high only while idle.
module array_binary_tree_engine_unit
    import abte_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[3:0], node_index[11:4], node_value[43:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], out_value[34:3], out_index[40:35],
                                   // node_count[47:41], tree_height[51:48],
                                   // is_complete[52]
    output logic        m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = AW + 2;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int DW = $clog2(AW + 2);
    localparam int HX = DW + 4;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_INS, S_DEL, S_SCAN, S_WALK, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        D_ENTER, D_FROM_L, D_FROM_R
    } dir_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [31:0]       val_reg, val_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [FW-1:0]     fill_reg, fill_next;
    dir_t              dir_reg, dir_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [DW-1:0]     hplus_reg, hplus_next;
    logic [FW-1:0]     cnt_reg, cnt_next;
    logic              ok_reg, ok_next;
    logic              seen_reg, seen_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [31:0]       pend_value_reg, pend_value_next;
    logic [AW-1:0]     pend_index_reg, pend_index_next;
    status_t           res_status_reg, res_status_next;
    logic [31:0]       res_value_reg, res_value_next;
    logic [AW-1:0]     res_index_reg, res_index_next;

    logic              m_valid_reg, m_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [31:0]       out_value_reg, out_value_next;
    logic [5:0]        out_index_reg, out_index_next;
    logic [6:0]        out_count_reg, out_count_next;
    logic [3:0]        out_height_reg, out_height_next;
    logic              out_complete_reg, out_complete_next;
    logic              out_last_reg, out_last_next;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [31:0]       mem_wd;
    logic [31:0]       rdata;

    func_t             in_func;
    logic [7:0]        in_idx;
    logic [31:0]       in_val;
    logic              out_free;
    logic              occ;
    logic              stall;
    logic              emit_go;
    logic              go_up;
    logic              do_emit;
    logic              is_trav;

    assign in_func = func_t'(s_tdata[3:0]);
    assign in_idx  = s_tdata[11:4];
    assign in_val  = s_tdata[43:12];

    abte_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (idx_next[AW-1:0]),
        .rd_data (rdata)
    );

    always_comb begin
        state_next        = state_reg;
        func_next         = func_reg;
        val_next          = val_reg;
        idx_next          = idx_reg;
        fill_next         = fill_reg;
        dir_next          = dir_reg;
        depth_next        = depth_reg;
        hplus_next        = hplus_reg;
        cnt_next          = cnt_reg;
        ok_next           = ok_reg;
        seen_next         = seen_reg;
        pend_valid_next   = pend_valid_reg;
        pend_value_next   = pend_value_reg;
        pend_index_next   = pend_index_reg;
        res_status_next   = res_status_reg;
        res_value_next    = res_value_reg;
        res_index_next    = res_index_reg;
        m_valid_next      = m_valid_reg;
        out_status_next   = out_status_reg;
        out_value_next    = out_value_reg;
        out_index_next    = out_index_reg;
        out_count_next    = out_count_reg;
        out_height_next   = out_height_reg;
        out_complete_next = out_complete_reg;
        out_last_next     = out_last_reg;
        mem_we            = 1'b0;
        mem_wa            = idx_reg[AW-1:0];
        mem_wd            = EMPTY_SLOT;
        emit_go           = 1'b0;
        go_up             = 1'b0;
        do_emit           = 1'b0;

        out_free = !m_valid_reg || m_tready;
        stall    = pend_valid_reg && !out_free;
        occ      = (idx_reg < IW'(fill_reg)) && (rdata != EMPTY_SLOT);
        is_trav  = (func_reg == FN_PRE) || (func_reg == FN_IN) ||
                   (func_reg == FN_POST) || (func_reg == FN_LEVEL);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (idx_reg == IW'(CAPACITY - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next       = in_func;
                    val_next        = in_val;
                    idx_next        = IW'(in_idx);
                    cnt_next        = '0;
                    hplus_next      = '0;
                    depth_next      = '0;
                    ok_next         = 1'b1;
                    seen_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    dir_next        = D_ENTER;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    res_index_next  = '0;
                    case (in_func)
                        FN_INSERT: begin
                            if (32'(in_idx) >= 32'(CAPACITY)) begin
                                res_status_next = ST_OOB;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_INS;
                            end
                        end
                        FN_APPEND: begin
                            if (fill_reg >= FW'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                mem_we         = 1'b1;
                                mem_wa         = AW'(fill_reg);
                                mem_wd         = in_val;
                                res_index_next = AW'(fill_reg);
                                fill_next      = fill_reg + 1'b1;
                            end
                            state_next = S_FIN;
                        end
                        FN_DELETE: begin
                            if (32'(in_idx) >= 32'(fill_reg)) begin
                                res_status_next = ST_INVALID;
                                state_next      = S_FIN;
                            end else begin
                                state_next = S_DEL;
                            end
                        end
                        FN_SEARCH, FN_COUNT, FN_COMPLETE, FN_LEVEL: begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        FN_HEIGHT, FN_PRE, FN_IN, FN_POST: begin
                            idx_next   = '0;
                            state_next = S_WALK;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                mem_we          = 1'b1;
                mem_wd          = val_reg;
                res_status_next = (rdata != EMPTY_SLOT) ? ST_OVERWROTE : ST_OK;
                res_index_next  = idx_reg[AW-1:0];
                if (idx_reg >= IW'(fill_reg)) begin
                    fill_next = FW'(idx_reg + 1'b1);
                end
                state_next = S_FIN;
            end
            S_DEL: begin
                if (rdata == EMPTY_SLOT) begin
                    res_status_next = ST_INVALID;
                end else begin
                    mem_we         = 1'b1;
                    res_value_next = rdata;
                    res_index_next = idx_reg[AW-1:0];
                end
                state_next = S_FIN;
            end
            S_SCAN: begin
                if (idx_reg >= IW'(fill_reg)) begin
                    if (func_reg == FN_SEARCH) begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_FIN;
                end else begin
                    case (func_reg)
                        FN_SEARCH: begin
                            if (rdata == val_reg) begin
                                res_index_next = idx_reg[AW-1:0];
                                state_next     = S_FIN;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        FN_COUNT: begin
                            if (occ) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            idx_next = idx_reg + 1'b1;
                        end
                        FN_COMPLETE: begin
                            if (!occ) begin
                                seen_next = 1'b1;
                            end else if (seen_reg) begin
                                ok_next = 1'b0;
                            end
                            idx_next = idx_reg + 1'b1;
                        end
                        default: begin
                            if (!occ) begin
                                idx_next = idx_reg + 1'b1;
                            end else if (!stall) begin
                                emit_go  = 1'b1;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                unique case (dir_reg)
                    D_ENTER: begin
                        do_emit = (func_reg == FN_PRE);
                        if (!occ) begin
                            go_up = 1'b1;
                        end else if (!(do_emit && stall)) begin
                            emit_go = do_emit;
                            if ((depth_reg + 1'b1) > hplus_reg) begin
                                hplus_next = depth_reg + 1'b1;
                            end
                            idx_next   = {idx_reg[IW-2:0], 1'b1};
                            depth_next = depth_reg + 1'b1;
                            dir_next   = D_ENTER;
                        end
                    end
                    D_FROM_L: begin
                        do_emit = (func_reg == FN_IN);
                        if (!(do_emit && stall)) begin
                            emit_go    = do_emit;
                            idx_next   = {idx_reg[IW-2:0], 1'b0} + IW'(2);
                            depth_next = depth_reg + 1'b1;
                            dir_next   = D_ENTER;
                        end
                    end
                    default: begin
                        do_emit = (func_reg == FN_POST);
                        if (!(do_emit && stall)) begin
                            emit_go = do_emit;
                            go_up   = 1'b1;
                        end
                    end
                endcase
                if (go_up) begin
                    if (idx_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next   = (idx_reg - 1'b1) >> 1;
                        dir_next   = idx_reg[0] ? D_FROM_L : D_FROM_R;
                        depth_next = depth_reg - 1'b1;
                    end
                end
            end
            default: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    out_last_next     = 1'b1;
                    out_count_next    = '0;
                    out_height_next   = '0;
                    out_complete_next = 1'b0;
                    if (is_trav) begin
                        if (pend_valid_reg) begin
                            out_status_next = ST_OK;
                            out_value_next  = pend_value_reg;
                            out_index_next  = 6'(pend_index_reg);
                        end else begin
                            out_status_next = ST_EMPTY_TRAV;
                            out_value_next  = '0;
                            out_index_next  = '0;
                        end
                    end else begin
                        out_status_next = res_status_reg;
                        out_value_next  = res_value_reg;
                        out_index_next  = 6'(res_index_reg);
                        if (func_reg == FN_COUNT) begin
                            out_count_next = 7'(cnt_reg);
                        end
                        if (func_reg == FN_HEIGHT) begin
                            out_height_next = 4'(HX'(hplus_reg) - HX'(1));
                        end
                        if (func_reg == FN_COMPLETE) begin
                            out_complete_next = ok_reg;
                        end
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
        endcase

        // hand the held node to the output, keep the new one until the next arrives
        if (emit_go) begin
            if (pend_valid_reg) begin
                m_valid_next      = 1'b1;
                out_status_next   = ST_OK;
                out_value_next    = pend_value_reg;
                out_index_next    = 6'(pend_index_reg);
                out_count_next    = '0;
                out_height_next   = '0;
                out_complete_next = 1'b0;
                out_last_next     = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_value_next = rdata;
            pend_index_next = idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            fill_reg       <= '0;
            dir_reg        <= D_ENTER;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            fill_reg       <= fill_next;
            dir_reg        <= dir_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        func_reg         <= func_next;
        val_reg          <= val_next;
        depth_reg        <= depth_next;
        hplus_reg        <= hplus_next;
        cnt_reg          <= cnt_next;
        ok_reg           <= ok_next;
        seen_reg         <= seen_next;
        pend_value_reg   <= pend_value_next;
        pend_index_reg   <= pend_index_next;
        res_status_reg   <= res_status_next;
        res_value_reg    <= res_value_next;
        res_index_reg    <= res_index_next;
        out_status_reg   <= out_status_next;
        out_value_reg    <= out_value_next;
        out_index_reg    <= out_index_next;
        out_count_reg    <= out_count_next;
        out_height_reg   <= out_height_next;
        out_complete_reg <= out_complete_next;
        out_last_reg     <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_complete_reg, out_height_reg, out_count_reg,
                       out_index_reg, out_value_reg, out_status_reg};

endmodule

>>> rtl/abte_store.sv
module abte_store
    import abte_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEFAULT_CAPACITY)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
